>>> rtl/bdc_pkg.sv
// Package: shared types, constants and helpers for the distortion corrector.
package bdc_pkg;

   localparam int DEGREE_DEF = 5;
   localparam int NUM_CSR = 6;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_WSET,
      ST_PU,
      ST_PW,
      ST_BPROD,
      ST_BSCALE,
      ST_XY,
      ST_T,
      ST_MAC,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      CSR_MIN_X = 3'd0,
      CSR_MAX_X = 3'd1,
      CSR_MIN_Y = 3'd2,
      CSR_MAX_Y = 3'd3,
      CSR_MIN_Z = 3'd4,
      CSR_MAX_Z = 3'd5
   } csr_index_type;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_POINT = 1'b1;

   function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
      logic signed [31:0] r;
      if (v > 80'sh7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -80'sh8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Q16.16 product: floor shift for positive, ceil-of-magnitude for negative
   function automatic logic signed [31:0] mulq_fix(input logic signed [63:0] p);
      logic signed [63:0] r;
      if (p >= 0) begin
         r = p >>> 16;
      end else begin
         r = -((-p + 64'sd65535) >>> 16);
      end
      return sat32(80'(r));
   endfunction

   // binomial coefficient from Pascal's triangle rows
   function automatic logic [7:0] choose(input int n, input int k);
      int row [9];
      for (int r = 0; r < 9; r++) begin
         row[r] = 0;
      end
      row[0] = 1;
      for (int m = 1; m < 9; m++) begin
         if (m <= n) begin
            for (int r = 8; r > 0; r--) begin
               row[r] = row[r] + row[r - 1];
            end
         end
      end
      return 8'(row[k[3:0]]);
   endfunction

endpackage

>>> rtl/bdc_div.sv
// Serial signed divider: 64-bit dividend by 33-bit divisor, truncating quotient.
module bdc_div
   import bdc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  dividend,
   input  logic signed [32:0]  divisor,
   output logic                busy,
   output logic signed [63:0]  quotient
);

   logic [63:0] num_ff, num_in;
   logic [32:0] den_ff, den_in;
   logic [33:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic [33:0] trial;
   logic [33:0] shifted;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[32:0], num_ff[63]};
      trial   = shifted - {1'b0, den_ff};
      if (start) begin
         num_in  = dividend[63] ? 64'(-dividend) : 64'(dividend);
         den_in  = divisor[32] ? 33'(-divisor) : 33'(divisor);
         neg_in  = dividend[63] ^ divisor[32];
         rem_in  = '0;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial;
            num_in = {num_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            num_in = {num_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? 64'(-num_ff) : 64'(num_ff);

endmodule

>>> rtl/bernstein_distortion_correct.sv
// Top level: tensor-product Bernstein distortion corrector, one shared multiplier.
//
// Input channel req_*: op 0 loads one coefficient into the table (no result),
// op 1 corrects one point and yields one rsp_* transfer. A transfer happens
// when valid is high and stall is low. Configuration writes on csr_* set the
// per-axis box bounds; csr_ready is always high, write only while idle.
// After a load the next item may follow at once. For a point, per axis the
// sequencer runs a 64-step serial division plus a start and a capture step,
// then the basis powers; then per term the term product and three
// coefficient products, plus one xy product per D+1 terms, all on the one
// 32x32 multiplier. The next item may be taken in the cycle in which
// rsp_valid rises. A degenerate box skips the math and goes straight to
// the done state; again the next item may be taken as rsp_valid rises.
// The result register holds rsp_* while rsp_stall is high; a finished point
// waits in its last state until the register is free, stalling the input.
// Reset clears the box registers, the basis and the control; the
// coefficient table is undefined until loaded.
module bernstein_distortion_correct
   import bdc_pkg::*;
#(
   parameter int DEGREE = DEGREE_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [7:0]         req_coef_index,
   input  logic [1:0]         req_coef_axis,
   input  logic signed [31:0] req_coef_value,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic               req_point_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_corrected_x,
   output logic signed [31:0] rsp_corrected_y,
   output logic signed [31:0] rsp_corrected_z,
   output logic               rsp_range_error,
   output logic               rsp_batch_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]        csr_data
);

   localparam int NB     = DEGREE + 1;
   localparam int NTERMS = NB * NB * NB;
   localparam int NMEM   = 3 * NTERMS;
   localparam int AW     = $clog2(NMEM);
   localparam int BW     = $clog2(NB + 1);
   localparam int TW     = $clog2(NTERMS + 1);
   localparam int SW     = $clog2(3 * NB);

   logic signed [31:0] box_ff [NUM_CSR];
   logic signed [31:0] basis_ff [3*NB];
   logic signed [31:0] mem [NMEM];
   logic signed [31:0] mem_rd_ff;

   state_type state_ff, state_in;
   logic [1:0]  ax_ff, ax_in;
   logic [BW-1:0] i_ff, i_in, e_ff, e_in, j_ff, j_in, k_ff, k_in;
   logic [TW-1:0] term_ff, term_in;
   logic signed [31:0] pt_ff [3];
   logic signed [31:0] u_ff, u_in, w_ff, w_in, pu_ff, pu_in, pw_ff, pw_in;
   logic signed [31:0] bxy_ff, bxy_in, t_ff, t_in;
   logic signed [63:0] prod_ff;
   logic signed [40:0] acc_ff [3];
   logic last_ff, err_ff, err_in;
   logic rsp_valid_ff;
   logic signed [31:0] out_ff [3];
   logic out_err_ff, out_last_ff;

   logic signed [31:0] ma, mb;
   logic signed [63:0] mprod;
   logic signed [31:0] mq;
   logic div_start, div_busy;
   logic signed [63:0] div_q;
   logic signed [63:0] div_num;
   logic signed [32:0] div_den;
   logic [AW-1:0] rd_addr;
   logic [SW-1:0] bx_idx, by_idx, bz_idx, bw_idx;
   logic accept;
   logic degenerate;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign degenerate = (box_ff[CSR_MIN_X] == box_ff[CSR_MAX_X]) ||
                       (box_ff[CSR_MIN_Y] == box_ff[CSR_MAX_Y]) ||
                       (box_ff[CSR_MIN_Z] == box_ff[CSR_MAX_Z]);

   assign div_num = 64'(33'(pt_ff[ax_ff]) - 33'(box_ff[{ax_ff, 1'b0}])) <<< 16;
   assign div_den = 33'(box_ff[{ax_ff, 1'b1}]) - 33'(box_ff[{ax_ff, 1'b0}]);

   assign bx_idx = SW'(i_ff);
   assign by_idx = SW'(NB) + SW'(j_ff);
   assign bz_idx = SW'(2*NB) + SW'(k_ff);
   assign bw_idx = SW'(ax_ff) * SW'(NB) + SW'(i_ff);

   bdc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // shared multiplier operand select
   always_comb begin
      ma = pu_ff;
      mb = u_ff;
      unique case (state_ff)
         ST_PU:     begin ma = pu_ff;  mb = u_ff; end
         ST_PW:     begin ma = pw_ff;  mb = w_ff; end
         ST_BPROD:  begin ma = pu_ff;  mb = pw_ff; end
         ST_XY:     begin ma = basis_ff[bx_idx]; mb = basis_ff[by_idx]; end
         ST_T:      begin ma = bxy_ff; mb = basis_ff[bz_idx]; end
         ST_MAC:    begin ma = mem_rd_ff; mb = t_ff; end
         default:   begin ma = pu_ff; mb = u_ff; end
      endcase
   end
   assign mprod = 64'(ma) * 64'(mb);
   assign mq    = mulq_fix(prod_ff);

   assign rd_addr = AW'(ax_in) * AW'(NTERMS) + AW'(term_in);

   always_ff @(posedge clock) begin
      prod_ff <= mprod;
      mem_rd_ff <= mem[rd_addr];
      if (accept && req_op == OP_LOAD && {2'b00, req_coef_index} < 10'(NTERMS) &&
          req_coef_axis != 2'd3) begin
         mem[AW'(req_coef_axis) * AW'(NTERMS) + AW'(req_coef_index)] <= req_coef_value;
      end
   end

   // sequencer; each multiply state uses the phase bit ph_ff: phase 0 registers the product, phase 1 takes it
   logic ph_ff, ph_in;

   always_comb begin
      state_in = state_ff;
      ax_in = ax_ff; i_in = i_ff; e_in = e_ff; j_in = j_ff; k_in = k_ff;
      term_in = term_ff; ph_in = 1'b0;
      u_in = u_ff; w_in = w_ff; pu_in = pu_ff; pw_in = pw_ff;
      bxy_in = bxy_ff; t_in = t_ff; err_in = err_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_POINT) begin
               ax_in = '0;
               err_in = degenerate;
               if (degenerate) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV;
                  ph_in = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (ph_ff) begin
               div_start = 1'b1;
            end else if (!div_busy) begin
               u_in = sat32(80'(div_q));
               state_in = ST_WSET;
            end
         end
         ST_WSET: begin
            w_in = sat32(80'(33'sd65536 - 33'(u_ff)));
            i_in = '0; e_in = '0;
            pu_in = 32'sd65536; pw_in = 32'sd65536;
            state_in = ST_PU;
         end
         ST_PU: begin
            if (e_ff == i_ff) begin
               e_in = '0; state_in = ST_PW;
            end else if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               pu_in = mq; e_in = e_ff + 1'b1;
            end
         end
         ST_PW: begin
            if (e_ff == BW'(DEGREE) - i_ff) begin
               state_in = ST_BPROD;
            end else if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               pw_in = mq; e_in = e_ff + 1'b1;
            end
         end
         ST_BPROD: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               pu_in = mq;
               state_in = ST_BSCALE;
            end
         end
         ST_BSCALE: begin
            pu_in = 32'sd65536; pw_in = 32'sd65536; e_in = '0;
            if (i_ff == BW'(DEGREE)) begin
               if (ax_ff == 2'd2) begin
                  i_in = '0; j_in = '0; k_in = '0; term_in = '0; ax_in = '0;
                  state_in = ST_XY;
               end else begin
                  ax_in = ax_ff + 2'd1;
                  ph_in = 1'b1;
                  state_in = ST_DIV;
               end
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_PU;
            end
         end
         ST_XY: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               bxy_in = mq; k_in = '0;
               state_in = ST_T;
            end
         end
         ST_T: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               t_in = mq; ax_in = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            // phase 0: memory read lands; phase 1: product lands
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (ax_ff != 2'd2) begin
               ax_in = ax_ff + 2'd1;
            end else begin
               ax_in = '0;
               term_in = term_ff + 1'b1;
               if (k_ff != BW'(DEGREE)) begin
                  k_in = k_ff + 1'b1;
                  state_in = ST_T;
               end else if (j_ff != BW'(DEGREE)) begin
                  j_in = j_ff + 1'b1;
                  state_in = ST_XY;
               end else if (i_ff != BW'(DEGREE)) begin
                  i_in = i_ff + 1'b1; j_in = '0;
                  state_in = ST_XY;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // MAC in phase 1 needs product of mem_rd and t; mem_rd is registered from the address,
   // so the product is captured on phase 1 entry and accumulated in phase 1.
   logic mac_fire;
   assign mac_fire = (state_ff == ST_MAC) && ph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ph_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < NUM_CSR; r++) box_ff[r] <= '0;
         for (int r = 0; r < 3*NB; r++) basis_ff[r] <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff <= ph_in;
         if (csr_valid && csr_ready && csr_index < CSR_IDX_W'(NUM_CSR)) begin
            box_ff[csr_index] <= csr_data;
         end
         if (state_ff == ST_BSCALE) begin
            basis_ff[bw_idx] <=
               sat32(80'($signed({1'b0, choose(DEGREE, int'(i_ff))})) * 80'(pu_ff));
         end
         if (state_ff == ST_DONE && !rsp_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      ax_ff <= ax_in; i_ff <= i_in; e_ff <= e_in; j_ff <= j_in; k_ff <= k_in;
      term_ff <= term_in;
      u_ff <= u_in; w_ff <= w_in; pu_ff <= pu_in; pw_ff <= pw_in;
      bxy_ff <= bxy_in; t_ff <= t_in; err_ff <= err_in;
      if (accept && req_op == OP_POINT) begin
         pt_ff[0] <= req_point_x;
         pt_ff[1] <= req_point_y;
         pt_ff[2] <= req_point_z;
         last_ff <= req_point_last;
         for (int a = 0; a < 3; a++) acc_ff[a] <= '0;
      end else if (mac_fire) begin
         acc_ff[ax_ff] <= acc_ff[ax_ff] + 41'(mq);
      end
      if (state_ff == ST_DONE && !rsp_valid_ff) begin
         for (int a = 0; a < 3; a++) begin
            out_ff[a] <= err_ff ? 32'sd0 : sat32(80'(acc_ff[a]));
         end
         out_err_ff  <= err_ff;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_corrected_x = out_ff[0];
   assign rsp_corrected_y = out_ff[1];
   assign rsp_corrected_z = out_ff[2];
   assign rsp_range_error = out_err_ff;
   assign rsp_batch_last  = out_last_ff;

`ifndef NO_ASSERTIONS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input taken while busy");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result without finished item");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_err_ff) |-> (out_ff[0] == 0 && out_ff[1] == 0 && out_ff[2] == 0))
      else $error("range error with nonzero output");
`endif

endmodule

>>> sim/tb_bernstein_distortion_correct.sv
// Testbench for the Bernstein distortion corrector: random and directed traffic vs. a predictor.
module tb_bernstein_distortion_correct
   import bdc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEG    = DEGREE_DEF;
   localparam int NB     = DEG + 1;
   localparam int NTERMS = NB * NB * NB;
   localparam longint ONE_Q = 65536;
   localparam longint LIMIT = 40_000_000;

   typedef struct {
      logic               op;
      logic [7:0]         idx;
      logic [1:0]         axis;
      logic signed [31:0] cv;
      logic signed [31:0] px, py, pz;
      logic               last;
   } req_item_type;

   typedef struct {
      logic signed [31:0] x, y, z;
      logic               err;
      logic               last;
   } point_result_type;

   class correction_scoreboard;
      longint           box[6];
      longint           coef[3][NTERMS];
      longint           wt[3][NB];
      point_result_type pending_q[$];
      int               errors;

      function new();
         foreach (box[i]) box[i] = 0;
         foreach (coef[a, t]) coef[a][t] = 0;
         errors = 0;
      endfunction

      function longint sat(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint qmul(longint a, longint b);
         longint p;
         p = a * b;
         if (p >= 0) return sat(p >>> 16);
         return sat(-((-p + 65535) >>> 16));
      endfunction

      function longint binom(int r);
         longint c;
         c = 1;
         for (int m = 0; m < r; m++) c = c * (DEG - m) / (m + 1);
         return c;
      endfunction

      function void set_box(int i, logic [31:0] d);
         if (i < 6) box[i] = longint'($signed(d));
      endfunction

      function void axis_weights(int a, longint u);
         longint w, pu, pw;
         w = sat(ONE_Q - u);
         for (int i = 0; i < NB; i++) begin
            pu = ONE_Q;
            pw = ONE_Q;
            for (int e = 0; e < i; e++) pu = qmul(pu, u);
            for (int e = 0; e < DEG - i; e++) pw = qmul(pw, w);
            wt[a][i] = sat(binom(i) * qmul(pu, pw));
         end
      endfunction

      function void note_input(req_item_type it);
         point_result_type r;
         longint acc[3], pt[3], bxy, t, num, den;
         if (it.op == OP_LOAD) begin
            if (it.idx < NTERMS && it.axis < 3) coef[it.axis][it.idx] = it.cv;
            return;
         end
         pt[0] = it.px;
         pt[1] = it.py;
         pt[2] = it.pz;
         acc = '{0, 0, 0};
         r.err = (box[0] == box[1]) || (box[2] == box[3]) || (box[4] == box[5]);
         if (!r.err) begin
            for (int a = 0; a < 3; a++) begin
               num = pt[a] - box[2*a];
               den = box[2*a+1] - box[2*a];
               axis_weights(a, sat((num * ONE_Q) / den));
            end
            for (int i = 0; i < NB; i++)
               for (int j = 0; j < NB; j++) begin
                  bxy = qmul(wt[0][i], wt[1][j]);
                  for (int k = 0; k < NB; k++) begin
                     t = qmul(bxy, wt[2][k]);
                     for (int a = 0; a < 3; a++)
                        acc[a] += qmul(coef[a][(i*NB + j)*NB + k], t);
                  end
               end
         end
         r.x = 32'(sat(acc[0]));
         r.y = 32'(sat(acc[1]));
         r.z = 32'(sat(acc[2]));
         r.last = it.last;
         pending_q.push_back(r);
      endfunction

      function void check_result(point_result_type act);
         point_result_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h z=%h", $time, act.x, act.y, act.z);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (act.x !== e.x) begin
            $display("%0t: corrected_x exp %h got %h", $time, e.x, act.x); errors++;
         end
         if (act.y !== e.y) begin
            $display("%0t: corrected_y exp %h got %h", $time, e.y, act.y); errors++;
         end
         if (act.z !== e.z) begin
            $display("%0t: corrected_z exp %h got %h", $time, e.z, act.z); errors++;
         end
         if (act.err !== e.err) begin
            $display("%0t: range_error exp %b got %b", $time, e.err, act.err); errors++;
         end
         if (act.last !== e.last) begin
            $display("%0t: batch_last exp %b got %b", $time, e.last, act.last); errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic               req_op = 0;
   logic [7:0]         req_coef_index = 0;
   logic [1:0]         req_coef_axis = 0;
   logic signed [31:0] req_coef_value = 0;
   logic signed [31:0] req_point_x = 0, req_point_y = 0, req_point_z = 0;
   logic               req_point_last = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [31:0] rsp_corrected_x, rsp_corrected_y, rsp_corrected_z;
   logic               rsp_range_error, rsp_batch_last;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [31:0]        csr_data = 0;

   correction_scoreboard sb;
   bit     offering = 0;
   int     burst_left = 0;
   bit     long_hold_req = 0;
   int     hold_left = 0;
   int     stretch_left = 0;
   int     stall_mode = 0;
   longint cycles = 0;

   bernstein_distortion_correct uut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: check transfers, stall on a pattern of its own
   always @(posedge clock) begin
      point_result_type act;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            act.x = rsp_corrected_x;
            act.y = rsp_corrected_y;
            act.z = rsp_corrected_z;
            act.err = rsp_range_error;
            act.last = rsp_batch_last;
            sb.check_result(act);
         end
         if (long_hold_req) begin
            hold_left = 8000;
            long_hold_req = 0;
         end
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(50, 400);
            stall_mode = $urandom_range(0, 2);
         end
         stretch_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else if (stall_mode == 0) begin
            rsp_stall <= 0;
         end else if (stall_mode == 1) begin
            rsp_stall <= ($urandom_range(0, 9) < 3);
         end else begin
            rsp_stall <= ($urandom_range(0, 9) < 8);
         end
      end
   end

   task automatic send_item(req_item_type it);
      req_valid <= 1;
      offering = 1;
      req_op <= it.op;
      req_coef_index <= it.idx;
      req_coef_axis <= it.axis;
      req_coef_value <= it.cv;
      req_point_x <= it.px;
      req_point_y <= it.py;
      req_point_z <= it.pz;
      req_point_last <= it.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(it);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 0;
         offering = 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
   endtask

   task automatic wait_idle();
      if (offering) begin
         req_valid <= 0;
         offering = 0;
         @(posedge clock);
      end
      while (sb.pending_q.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_box(int'(idx), d);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic write_box(logic [31:0] x0, x1, y0, y1, z0, z1);
      wait_idle();
      csr_write(CSR_MIN_X, x0);
      csr_write(CSR_MAX_X, x1);
      csr_write(CSR_MIN_Y, y0);
      csr_write(CSR_MAX_Y, y1);
      csr_write(CSR_MIN_Z, z0);
      csr_write(CSR_MAX_Z, z1);
   endtask

   task automatic load(int axis, int idx, logic [31:0] v);
      req_item_type it;
      it = '{OP_LOAD, 8'(idx), 2'(axis), v, $urandom, $urandom, $urandom, 1'($urandom)};
      send_item(it);
   endtask

   task automatic point(logic [31:0] x, y, z, logic last);
      req_item_type it;
      it = '{OP_POINT, 8'($urandom), 2'($urandom), $urandom, x, y, z, last};
      send_item(it);
   endtask

   function automatic logic [31:0] coord(int a);
      longint lo, hi;
      longint unsigned r;
      lo = (sb.box[2*a] < sb.box[2*a+1]) ? sb.box[2*a] : sb.box[2*a+1];
      hi = (sb.box[2*a] < sb.box[2*a+1]) ? sb.box[2*a+1] : sb.box[2*a];
      r = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: return 32'(sb.sat(hi + $urandom_range(0, 65536)));
         3: return 32'(sb.sat(lo - $urandom_range(0, 65536)));
         default: return 32'(lo + longint'(r % longint'(hi - lo + 1)));
      endcase
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      endcase
   endfunction

   task automatic random_phase(int n, bit pressure);
      int cnt;
      cnt = 0;
      while (cnt < n) begin
         if (pressure && cnt == n / 2) begin
            long_hold_req = 1;
            repeat (8) point(coord(0), coord(1), coord(2), 1'($urandom));
            wait_idle();
         end
         if ($urandom_range(0, 99) < 45) begin
            point(coord(0), coord(1), coord(2), 1'($urandom));
            cnt++;
         end else if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1)) load($urandom_range(0, 3), $urandom_range(NTERMS, 255),
                                           $urandom);
            else load(3, $urandom_range(0, 255), $urandom);
         end else begin
            load($urandom_range(0, 2), $urandom_range(0, NTERMS - 1), rand_coef());
            cnt++;
         end
      end
   endtask

   initial begin
      logic [31:0] m;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // fill the whole table before any point reads it
      for (int a = 0; a < 3; a++)
         for (int i = 0; i < NTERMS; i++)
            load(a, i, (i == 0) ? 32'h7FFF_FFFF : (i == 1) ? 32'h8000_0000 :
                       (i == 2) ? 32'h0 : rand_coef());
      point(32'h0, 32'h0, 32'h0, 1'b0);
      point(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 1'b1);
      write_box(32'hFFFF_0000, 32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000,
                32'h0, 32'h0000_8000);
      point(32'hFFFF_0000, 32'hFFFE_0000, 32'h0, 1'b0);
      point(32'h0001_0000, 32'h0003_0000, 32'h0000_8000, 1'b0);
      point(32'h0, 32'h0000_8000, 32'h0000_4000, 1'b1);
      point(32'h0004_0000, 32'hFFF0_0000, 32'h0002_0000, 1'b0);
      point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
      load(0, 255, 32'h1234_5678);
      load(3, 0, 32'hFFFF_FFFF);
      load(1, 5, 32'h7FFF_FFFF);
      point(32'h0000_4000, 32'h0, 32'h0000_2000, 1'b1);
      write_box(32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000,
                32'h0, 32'h0001_0000);
      point(32'h0, 32'h0, 32'h0, 1'b1);
      write_box(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0, 32'h5, 32'h0);
      point(32'h0, 32'h0001_0000, 32'h2, 1'b0);
      write_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000);
      point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1);
      write_box(32'h0, 32'h1, 32'h0, 32'h1, 32'h0, 32'h1);
      point(32'h1, 32'h0, 32'h2, 1'b0);
      wait_idle();
      csr_write(3'd7, 32'hFFFF_FFFF);
      csr_write(3'd6, 32'h0);
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_box(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                         32'hFFFF_0000, 32'h0001_0000);
            1: write_box(32'h0, 32'h0010_0000, 32'hFFF0_0000, 32'h0, 32'h0, 32'h0001_0000);
            4: write_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0000_0100,
                         32'h0001_0000, 32'hFFFF_0000);
            default: begin
               wait_idle();
               for (int a = 0; a < 3; a++) begin
                  m = $urandom;
                  csr_write(CSR_IDX_W'(2*a), m);
                  csr_write(CSR_IDX_W'(2*a + 1),
                            32'(longint'($signed(m)) + $urandom_range(1, 1 << 20)));
               end
            end
         endcase
         random_phase(200, ph == 2);
      end
      wait_idle();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
